// ===== rtl/core/dmmfb_pkg.sv =====
// Shared types and constants of the dual motor drive frame builder.
`timescale 1ns / 1ps

package dmmfb_pkg;

	// Modbus RTU write-single-register framing
	localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
	localparam logic [7:0]  REG_HI            = 8'h20;
	localparam logic [15:0] CRC_INIT          = 16'hFFFF;
	localparam logic [15:0] CRC_POLY          = 16'hA001;
	localparam int          FRAME_BYTES       = 8;

	// Values written to the mode register
	localparam logic [3:0] MODE_FORWARD = 4'd1;
	localparam logic [3:0] MODE_REVERSE = 4'd2;
	localparam logic [3:0] MODE_BRAKE   = 4'd9;

	// Configuration register indexes
	localparam logic [1:0] CFG_LEFT_ADDR  = 2'd0;
	localparam logic [1:0] CFG_RIGHT_ADDR = 2'd1;
	localparam logic [1:0] CFG_SPEED_SCALE = 2'd2;

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic [1:0] {
		DIR_UNKNOWN = 2'd0,
		DIR_FWD     = 2'd1,
		DIR_REV     = 2'd2
	} dir_t;

	// Current configuration, as seen by the front end
	typedef struct packed {
		logic [7:0] left_addr;
		logic [7:0] right_addr;
		logic [7:0] speed_scale;
	} cfg_t;

	// One frame to be serialized
	typedef struct packed {
		logic [7:0]  addr;
		logic        is_speed;
		logic [15:0] value;
		logic        last;
	} frame_desc_t;

endpackage

// ===== rtl/core/dmmfb_front.sv =====
// Front end: accepts commands, tracks drive directions and issues frame descriptors.
`timescale 1ns / 1ps

module dmmfb_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   command,
	input  logic signed [13:0]     left_speed,
	input  logic signed [13:0]     right_speed,
	input  dmmfb_pkg::cfg_t        cfg,
	output logic                   push_valid,
	input  logic                   push_ready,
	output dmmfb_pkg::frame_desc_t push_data
);

	// |speed| * scale, saturated to 16 bits
	function automatic logic [15:0] scale_speed(input logic signed [13:0] s,
		input logic [7:0] k);
		logic [13:0] mag;
		logic [21:0] prod;
		mag  = s[13] ? 14'(-s) : 14'(s);
		prod = {8'b0, mag} * {14'b0, k};
		return (|prod[21:16]) ? 16'hFFFF : prod[15:0];
	endfunction

	// Slots: 0 left mode, 1 right mode, 2 left speed, 3 right speed
	logic [3:0]  mask_s1;
	logic [3:0]  mode_s1 [2];
	logic [15:0] speed_s1 [2];
	dmmfb_pkg::dir_t dir_l_q, dir_r_q;

	logic [1:0] sel_idx;
	logic [3:0] sel_onehot;
	logic [3:0] rest;
	logic       push_fire;
	logic       accept;
	dmmfb_pkg::dir_t want_l, want_r;
	logic [3:0] new_mask;

	// Pick the lowest pending slot
	always_comb begin
		if (mask_s1[0]) begin
			sel_idx = 2'd0;
		end else if (mask_s1[1]) begin
			sel_idx = 2'd1;
		end else if (mask_s1[2]) begin
			sel_idx = 2'd2;
		end else begin
			sel_idx = 2'd3;
		end
	end

	assign sel_onehot = 4'b0001 << sel_idx;
	assign rest       = mask_s1 & ~sel_onehot;
	assign push_valid = |mask_s1;
	assign push_fire  = push_valid && push_ready;
	assign in_ready   = (mask_s1 == 4'b0) || (push_fire && (rest == 4'b0));
	assign accept     = in_valid && in_ready;

	// Build the descriptor of the selected slot
	always_comb begin
		push_data.addr     = sel_idx[0] ? cfg.right_addr : cfg.left_addr;
		push_data.is_speed = sel_idx[1];
		push_data.value    = sel_idx[1] ? speed_s1[sel_idx[0]] : {12'b0, mode_s1[sel_idx[0]]};
		push_data.last     = (rest == 4'b0);
	end

	// Classify: zero on the left is forward, zero on the right is reverse
	always_comb begin
		want_l = left_speed[13] ? dmmfb_pkg::DIR_REV : dmmfb_pkg::DIR_FWD;
		want_r = (!right_speed[13] && (right_speed != 14'sd0)) ?
			dmmfb_pkg::DIR_FWD : dmmfb_pkg::DIR_REV;
		if (command) begin
			new_mask = 4'b0011;
		end else begin
			new_mask = {2'b11, (dir_r_q != want_r), (dir_l_q != want_l)};
		end
	end

	// Hold pending slots and direction state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s1 <= 4'b0;
			dir_l_q <= dmmfb_pkg::DIR_UNKNOWN;
			dir_r_q <= dmmfb_pkg::DIR_UNKNOWN;
		end else if (accept) begin
			mask_s1 <= new_mask;
			dir_l_q <= command ? dmmfb_pkg::DIR_UNKNOWN : want_l;
			dir_r_q <= command ? dmmfb_pkg::DIR_UNKNOWN : want_r;
		end else if (push_fire) begin
			mask_s1 <= rest;
		end
	end

	// Load slot payload on each accepted transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			if (command) begin
				mode_s1[0] <= dmmfb_pkg::MODE_BRAKE;
				mode_s1[1] <= dmmfb_pkg::MODE_BRAKE;
			end else begin
				mode_s1[0] <= (want_l == dmmfb_pkg::DIR_FWD) ?
					dmmfb_pkg::MODE_FORWARD : dmmfb_pkg::MODE_REVERSE;
				mode_s1[1] <= (want_r == dmmfb_pkg::DIR_FWD) ?
					dmmfb_pkg::MODE_FORWARD : dmmfb_pkg::MODE_REVERSE;
			end
			speed_s1[0] <= scale_speed(left_speed, cfg.speed_scale);
			speed_s1[1] <= scale_speed(right_speed, cfg.speed_scale);
		end
	end

endmodule

// ===== rtl/core/dmmfb_fifo.sv =====
// Descriptor queue between the front end and the byte serializer.
`timescale 1ns / 1ps

module dmmfb_fifo #(
	parameter int DEPTH = dmmfb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push_valid,
	output logic                   push_ready,
	input  dmmfb_pkg::frame_desc_t push_data,
	output logic                   pop_valid,
	input  logic                   pop_ready,
	output dmmfb_pkg::frame_desc_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	dmmfb_pkg::frame_desc_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push_fire, pop_fire;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/core/dmmfb_back.sv =====
// Back end: serializes frame descriptors into bytes with CRC-16/MODBUS.
`timescale 1ns / 1ps

module dmmfb_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop_valid,
	output logic                   pop_ready,
	input  dmmfb_pkg::frame_desc_t pop_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             frame_byte,
	output logic                   last_byte
);

	localparam int CNT_W = $clog2(dmmfb_pkg::FRAME_BYTES);
	localparam logic [CNT_W-1:0] IDX_ADDR  = CNT_W'(0);
	localparam logic [CNT_W-1:0] IDX_FUNC  = CNT_W'(1);
	localparam logic [CNT_W-1:0] IDX_REGH  = CNT_W'(2);
	localparam logic [CNT_W-1:0] IDX_REGL  = CNT_W'(3);
	localparam logic [CNT_W-1:0] IDX_VALH  = CNT_W'(4);
	localparam logic [CNT_W-1:0] IDX_VALL  = CNT_W'(5);
	localparam logic [CNT_W-1:0] IDX_CRCL  = CNT_W'(6);
	localparam logic [CNT_W-1:0] IDX_CRCH  = CNT_W'(7);

	// Fold one byte into the CRC, bit by bit
	function automatic logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {8'b0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ dmmfb_pkg::CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	dmmfb_pkg::frame_desc_t cur_q;
	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      crc_q;
	logic             out_valid_q;
	logic [7:0]       frame_byte_q;
	logic             last_byte_q;

	logic       advance;
	logic       frame_end;
	logic       pop_fire;
	logic [7:0] byte_d;
	logic [15:0] crc_base;

	assign advance   = busy_q && (!out_valid_q || out_ready);
	assign frame_end = advance && (cnt_q == IDX_CRCH);
	assign pop_ready = !busy_q || frame_end;
	assign pop_fire  = pop_valid && pop_ready;
	assign crc_base  = (cnt_q == IDX_ADDR) ? dmmfb_pkg::CRC_INIT : crc_q;

	// Select the byte at the current frame position
	always_comb begin
		case (cnt_q)
			IDX_ADDR: byte_d = cur_q.addr;
			IDX_FUNC: byte_d = dmmfb_pkg::FUNC_WRITE_SINGLE;
			IDX_REGH: byte_d = dmmfb_pkg::REG_HI;
			IDX_REGL: byte_d = {7'b0, cur_q.is_speed};
			IDX_VALH: byte_d = cur_q.value[15:8];
			IDX_VALL: byte_d = cur_q.value[7:0];
			IDX_CRCL: byte_d = crc_q[7:0];
			IDX_CRCH: byte_d = crc_q[15:8];
			default:  byte_d = 8'h00;
		endcase
	end

	// Sequence bytes and drive the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_fire) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (frame_end) begin
				busy_q <= 1'b0;
			end else if (advance) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: descriptor, CRC accumulator and output byte
	always_ff @(posedge clk) begin
		if (pop_fire) begin
			cur_q <= pop_data;
		end
		if (advance && (cnt_q < IDX_CRCL)) begin
			crc_q <= crc_step(crc_base, byte_d);
		end
		if (advance) begin
			frame_byte_q <= byte_d;
			last_byte_q  <= cur_q.last && (cnt_q == IDX_CRCH);
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign last_byte  = last_byte_q;

endmodule

// ===== rtl/core/dual_motor_modbus_frame_builder.sv =====
// Top level: configuration registers, front end, descriptor queue and serializer.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------
//   in       | in_valid / in_ready  | command, left_speed, right_speed
//   out      | out_valid / out_ready| frame_byte, last_byte
//   cfg      | cfg_we (no wait)     | cfg_index, cfg_data
//
// A command yields 2 to 4 frames of 8 bytes, one byte per cycle while out_ready
// is high. The front end takes a new command as soon as its last frame enters the
// queue, so commands follow without gaps. Reset clears directions to unknown and
// configuration to addresses 1 and 2, scale 15. An output stall backs up through
// the queue to in_ready.
`timescale 1ns / 1ps

module dual_motor_modbus_frame_builder #(
	parameter int QUEUE_DEPTH = dmmfb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              command,
	input  logic signed [13:0] left_speed,
	input  logic signed [13:0] right_speed,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        frame_byte,
	output logic              last_byte,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data
);

	dmmfb_pkg::cfg_t        cfg_q;
	logic                   push_valid, push_ready;
	dmmfb_pkg::frame_desc_t push_data;
	logic                   pop_valid, pop_ready;
	dmmfb_pkg::frame_desc_t pop_data;

	// Write configuration registers; other indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_addr   <= 8'd1;
			cfg_q.right_addr  <= 8'd2;
			cfg_q.speed_scale <= 8'd15;
		end else if (cfg_we) begin
			case (cfg_index)
				dmmfb_pkg::CFG_LEFT_ADDR:   cfg_q.left_addr   <= cfg_data;
				dmmfb_pkg::CFG_RIGHT_ADDR:  cfg_q.right_addr  <= cfg_data;
				dmmfb_pkg::CFG_SPEED_SCALE: cfg_q.speed_scale <= cfg_data;
				default: ;
			endcase
		end
	end

	dmmfb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.left_speed  (left_speed),
		.right_speed (right_speed),
		.cfg         (cfg_q),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	dmmfb_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	dmmfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

	// An accepted command always leaves frames pending in the front end
	a_accept_issues: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> push_valid)
		else $error("accepted command left no frame pending");

	// A brake command starts with a mode frame
	a_brake_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && command) |=> (push_valid && !push_data.is_speed))
		else $error("brake did not start with a mode frame");

	// After the last frame of a command leaves, the front end is empty
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && push_ready && push_data.last && !(in_valid && in_ready))
		|=> !push_valid)
		else $error("frames pending after last frame of a command");

	// A closing speed frame is addressed to the right drive
	a_last_is_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && push_data.last && push_data.is_speed) |-> push_data.addr == cfg_q.right_addr)
		else $error("closing speed frame not addressed to the right drive");

endmodule
